/* sv/sparse_row_bitmap_index_core_macros.svh */
// Assertion macros for the sparse row bitmap index core.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SPARSE_ROW_BITMAP_INDEX_CORE_MACROS_SVH
`define SPARSE_ROW_BITMAP_INDEX_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define SRBI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// cond must never be true outside reset
`define SRBI_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SRBI_ASSERT(label, prop, msg)
`define SRBI_ASSERT_NEVER(label, cond, msg)
`endif
`endif

/* sv/srbi_pkg.sv */
// Shared constants, types and controller/datapath interface structs
// for the sparse row bitmap index core. No dependencies.
package srbi_pkg;

  // Geometry
  localparam int N_ROWS     = 128;
  localparam int MAX_BLOCKS = 16;
  localparam int WORD_BITS  = 32;

  // Port field widths
  localparam int CELL_REQ_W = 7;
  localparam int TID_W      = 21;
  localparam int BIT_POS_W  = 5;
  localparam int INDEX_W    = 4;
  localparam int ID_W       = 21;
  localparam int STATUS_W   = 2;

  // Derived widths
  localparam int KEY_W     = 16;
  localparam int MASK_W    = WORD_BITS;
  localparam int DEC_W     = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int LSB_W     = $clog2(DEC_W);
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int CELL_W    = (N_ROWS > 1) ? $clog2(N_ROWS) : 1;
  localparam int BLK_DEPTH = N_ROWS * MAX_BLOCKS;
  localparam int ADDR_W    = (BLK_DEPTH > 1) ? $clog2(BLK_DEPTH) : 1;

  // Request kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture request, read row count
    logic blk_rd;      // read addressed block
    logic commit_ins;  // write insert update, emit insert result
    logic emit_bad;    // emit bad-index result
    logic scan_load;   // load block mask for id decode
    logic scan_emit;   // emit lowest id, clear its bit
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
    logic idx_bad;
    logic mask_zero;
    logic mask_last;
    logic out_free;
  } status_t;

endpackage

/* sv/sparse_row_bitmap_index_core.sv */
// Sparse row bitmap index core. Each of 128 rows holds an ordered list of up
// to 16 blocks, each a 16-bit key (tid / 32) and a 32-bit mask. An insert
// (kind 0) appends a block when the row is empty or its last key differs and
// ORs bit_pos into the last block; it gives one result, status 1 if a new
// block is needed but the row is full. A read (kind 1) gives one result per
// set bit of the chosen block, lowest bit first, id = key*32 + bit, last on
// the final one; an empty block gives no result, an index past the row gives
// status 2. One request is in flight at a time: once it is taken, the row
// count and then the block are read, after which an insert or bad-index
// result is registered, or a read loads the block mask and registers one id
// per cycle (up to 32) while the output is free. The next request is taken
// the cycle after the final result is registered, even while it waits at
// the output. A result waits while the output register holds one not taken.
// The pace is set by two registered memory reads in series: the row count,
// then the block it addresses, followed by the update or decode.
// Depends on srbi_pkg, srbi_ctrl, srbi_dp and the assertion macro header.
`include "sparse_row_bitmap_index_core_macros.svh"

module sparse_row_bitmap_index_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  kind_i,
  input  logic [srbi_pkg::CELL_REQ_W-1:0]       cell_req_i,
  input  logic [srbi_pkg::TID_W-1:0]            tid_i,
  input  logic [srbi_pkg::BIT_POS_W-1:0]        bit_pos_i,
  input  logic [srbi_pkg::INDEX_W-1:0]          block_index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [srbi_pkg::STATUS_W-1:0]         status_o,
  output logic [srbi_pkg::ID_W-1:0]             id_o,
  output logic                                  last_o,
  output logic [srbi_pkg::CNT_W-1:0]            row_blocks_o
);

  srbi_pkg::cmd_t    cmd;
  srbi_pkg::status_t st;

  // Sequencer
  srbi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Storage, decode and output register
  srbi_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .kind_i        (kind_i),
    .cell_req_i    (cell_req_i),
    .tid_i         (tid_i),
    .bit_pos_i     (bit_pos_i),
    .block_index_i (block_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .id_o          (id_o),
    .last_o        (last_o),
    .row_blocks_o  (row_blocks_o)
  );

  // Checks
  `SRBI_ASSERT(a_one_cmd, $onehot0({cmd.load, cmd.blk_rd, cmd.commit_ins, cmd.emit_bad, cmd.scan_load, cmd.scan_emit}), "more than one datapath command at once")
  `SRBI_ASSERT(a_emit_free, (cmd.commit_ins || cmd.emit_bad || cmd.scan_emit) |-> st.out_free, "result written over a waiting result")
  `SRBI_ASSERT(a_take_then_look, (in_valid_i && in_ready_o) |=> cmd.blk_rd, "block read does not follow request transfer")
  `SRBI_ASSERT(a_insert_last, cmd.commit_ins |=> (out_valid_o && last_o && (id_o == '0)), "insert result not single with zero id")

endmodule

/* sv/srbi_ctrl.sv */
// Sequencing state machine for the sparse row bitmap index core.
// Depends on srbi_pkg for the command and status structs.
module srbi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  srbi_pkg::status_t st_i,
  output srbi_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.blk_rd = 1'b1;
        state_d      = S_DEC;
      end
      S_DEC: begin
        priority if (!st_i.is_read) begin
          if (st_i.out_free) begin
            cmd_o.commit_ins = 1'b1;
            state_d          = S_IDLE;
          end
        end else if (st_i.idx_bad) begin
          if (st_i.out_free) begin
            cmd_o.emit_bad = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.scan_load = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (st_i.mask_zero) begin
          state_d = S_IDLE;
        end else if (st_i.out_free) begin
          cmd_o.scan_emit = 1'b1;
          if (st_i.mask_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/srbi_dp.sv */
// Datapath of the sparse row bitmap index core: request registers, row
// count and block memories, id decode and output register. Uses srbi_pkg.
module srbi_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  srbi_pkg::cmd_t                        cmd_i,
  output srbi_pkg::status_t                     st_o,
  input  logic                                  kind_i,
  input  logic [srbi_pkg::CELL_REQ_W-1:0]       cell_req_i,
  input  logic [srbi_pkg::TID_W-1:0]            tid_i,
  input  logic [srbi_pkg::BIT_POS_W-1:0]        bit_pos_i,
  input  logic [srbi_pkg::INDEX_W-1:0]          block_index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [srbi_pkg::STATUS_W-1:0]         status_o,
  output logic [srbi_pkg::ID_W-1:0]             id_o,
  output logic                                  last_o,
  output logic [srbi_pkg::CNT_W-1:0]            row_blocks_o
);

  // Request registers
  logic                              kind_q;
  logic [srbi_pkg::CELL_REQ_W-1:0]   cell_q;
  logic [srbi_pkg::KEY_W-1:0]        key_q;
  logic [srbi_pkg::BIT_POS_W-1:0]    bit_q;
  logic [srbi_pkg::INDEX_W-1:0]      index_q;
  logic                              cell_ok_q;

  // Memories and their read registers
  logic [srbi_pkg::CNT_W-1:0]  cnt_mem [srbi_pkg::N_ROWS];
  logic [srbi_pkg::N_ROWS-1:0] cnt_vld_q;
  logic [srbi_pkg::KEY_W-1:0]  blk_key_mem  [srbi_pkg::BLK_DEPTH];
  logic [srbi_pkg::MASK_W-1:0] blk_mask_mem [srbi_pkg::BLK_DEPTH];
  logic [srbi_pkg::CNT_W-1:0]  cnt_q;
  logic [srbi_pkg::KEY_W-1:0]  blk_key_q;
  logic [srbi_pkg::MASK_W-1:0] blk_mask_q;

  // Decode registers
  logic [srbi_pkg::DEC_W-1:0] mask_q;
  logic [srbi_pkg::ID_W-1:0]  origin_q;

  // Output register
  logic                          out_valid_q;
  srbi_pkg::status_e             out_status_q;
  logic [srbi_pkg::ID_W-1:0]     out_id_q;
  logic                          out_last_q;
  logic [srbi_pkg::CNT_W-1:0]    out_blocks_q;

  logic                          in_cell_ok;
  logic [srbi_pkg::CELL_W-1:0]   in_cell_idx;
  logic [srbi_pkg::CELL_W-1:0]   cell_idx;
  logic [srbi_pkg::ADDR_W-1:0]   base;
  logic [srbi_pkg::ADDR_W-1:0]   last_addr;
  logic [srbi_pkg::ADDR_W-1:0]   rd_addr;
  logic [srbi_pkg::ADDR_W-1:0]   wr_addr;
  logic [srbi_pkg::KEY_W-1:0]    wr_key;
  logic [srbi_pkg::MASK_W-1:0]   wr_mask;
  logic [srbi_pkg::MASK_W-1:0]   bit_mask;
  logic                          need_new;
  logic                          row_full;
  logic                          ins_ok;
  logic                          blk_we;
  logic                          cnt_we;
  logic [srbi_pkg::CNT_W-1:0]    cnt_inc;
  logic [srbi_pkg::CNT_W-1:0]    ins_blocks;
  logic [srbi_pkg::LSB_W-1:0]    lsb;
  logic [srbi_pkg::DEC_W-1:0]    mask_rest;
  logic                          out_free;

  assign in_cell_ok  = 32'(cell_req_i) < srbi_pkg::N_ROWS;
  assign in_cell_idx = cell_req_i[srbi_pkg::CELL_W-1:0];
  assign cell_idx    = cell_q[srbi_pkg::CELL_W-1:0];

  // Capture request; key is the block number of tid
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= kind_i;
      cell_q    <= cell_req_i;
      key_q     <= srbi_pkg::KEY_W'(tid_i / srbi_pkg::WORD_BITS);
      bit_q     <= bit_pos_i;
      index_q   <= block_index_i;
      cell_ok_q <= in_cell_ok;
    end
  end

  // Addressing within the block store
  assign base      = srbi_pkg::ADDR_W'(cell_idx) * srbi_pkg::ADDR_W'(srbi_pkg::MAX_BLOCKS);
  assign last_addr = base + srbi_pkg::ADDR_W'(cnt_q) - srbi_pkg::ADDR_W'(1);
  assign rd_addr   = (kind_q == srbi_pkg::KIND_READ) ? base + srbi_pkg::ADDR_W'(index_q)
                                                     : last_addr;

  // Insert decision from count and last block
  assign need_new = (cnt_q == '0) || (blk_key_q != key_q);
  assign row_full = cnt_q >= srbi_pkg::CNT_W'(srbi_pkg::MAX_BLOCKS);
  assign ins_ok   = cell_ok_q && !(need_new && row_full);
  assign bit_mask = (32'(bit_q) < srbi_pkg::WORD_BITS) ? (srbi_pkg::MASK_W'(1) << bit_q) : '0;
  assign cnt_inc  = cnt_q + srbi_pkg::CNT_W'(1);
  assign blk_we   = cmd_i.commit_ins && ins_ok;
  assign cnt_we   = blk_we && need_new;
  assign wr_addr  = need_new ? base + srbi_pkg::ADDR_W'(cnt_q) : last_addr;
  assign wr_key   = need_new ? key_q : blk_key_q;
  assign wr_mask  = need_new ? bit_mask : (blk_mask_q | bit_mask);
  assign ins_blocks = (ins_ok && need_new) ? cnt_inc : cnt_q;

  // Row count memory; rows never written read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cnt_q <= (in_cell_ok && cnt_vld_q[in_cell_idx]) ? cnt_mem[in_cell_idx] : '0;
    end
    if (cnt_we) begin
      cnt_mem[cell_idx] <= cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cnt_we) begin
      cnt_vld_q[cell_idx] <= 1'b1;
    end
  end

  // Block key/mask memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.blk_rd) begin
      blk_key_q  <= blk_key_mem[rd_addr];
      blk_mask_q <= blk_mask_mem[rd_addr];
    end
    if (blk_we) begin
      blk_key_mem[wr_addr]  <= wr_key;
      blk_mask_mem[wr_addr] <= wr_mask;
    end
  end

  // Lowest set bit of the remaining mask
  always_comb begin
    lsb = '0;
    for (int i = srbi_pkg::DEC_W - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        lsb = srbi_pkg::LSB_W'(i);
      end
    end
  end

  assign mask_rest = mask_q & (mask_q - srbi_pkg::DEC_W'(1));

  // Id decode registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_load) begin
      mask_q   <= blk_mask_q[srbi_pkg::DEC_W-1:0];
      origin_q <= srbi_pkg::ID_W'(32'(blk_key_q) * srbi_pkg::WORD_BITS);
    end else if (cmd_i.scan_emit) begin
      mask_q <= mask_rest;
    end
  end

  // Output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit_ins || cmd_i.emit_bad || cmd_i.scan_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.commit_ins) begin
      out_status_q <= ins_ok ? srbi_pkg::ST_OK : srbi_pkg::ST_FULL;
      out_id_q     <= '0;
      out_last_q   <= 1'b1;
      out_blocks_q <= ins_blocks;
    end else if (cmd_i.emit_bad) begin
      out_status_q <= srbi_pkg::ST_BAD_INDEX;
      out_id_q     <= '0;
      out_last_q   <= 1'b1;
      out_blocks_q <= cnt_q;
    end else if (cmd_i.scan_emit) begin
      out_status_q <= srbi_pkg::ST_OK;
      out_id_q     <= origin_q + srbi_pkg::ID_W'(lsb);
      out_last_q   <= (mask_rest == '0);
      out_blocks_q <= cnt_q;
    end else begin
      out_status_q <= out_status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign id_o         = out_id_q;
  assign last_o       = out_last_q;
  assign row_blocks_o = out_blocks_q;

  // Status to controller
  assign st_o.is_read   = (kind_q == srbi_pkg::KIND_READ);
  assign st_o.idx_bad   = 32'(index_q) >= 32'(cnt_q);
  assign st_o.mask_zero = (mask_q == '0);
  assign st_o.mask_last = (mask_rest == '0);
  assign st_o.out_free  = out_free;

endmodule

/* tb/sv/sparse_row_bitmap_index_core_tb.sv */
// Self-checking testbench for sparse_row_bitmap_index_core: directed and random
// inserts and block reads, checked against a behavioral predictor of the rows.
// Depends on srbi_pkg and the core RTL.
module sparse_row_bitmap_index_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 2000;  // cycles without any transfer
  localparam int DRAIN_WAIT   = 48;    // latency margin after the last result
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 31;    // per idling phase
  localparam logic [srbi_pkg::CELL_REQ_W-1:0] FULL_ROW = 7'd9;

  // One result of the core
  typedef struct packed {
    srbi_pkg::status_e               status;
    logic [srbi_pkg::ID_W-1:0]       id;
    logic                            last;
    logic [srbi_pkg::CNT_W-1:0]      blocks;
  } index_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic                            kind_i;
  logic [srbi_pkg::CELL_REQ_W-1:0] cell_req_i;
  logic [srbi_pkg::TID_W-1:0]      tid_i;
  logic [srbi_pkg::BIT_POS_W-1:0]  bit_pos_i;
  logic [srbi_pkg::INDEX_W-1:0]    block_index_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [srbi_pkg::STATUS_W-1:0]   status_o;
  logic [srbi_pkg::ID_W-1:0]       id_o;
  logic                            last_o;
  logic [srbi_pkg::CNT_W-1:0]      row_blocks_o;

  // Predicted row contents
  int unsigned                  row_fill [srbi_pkg::N_ROWS];
  logic [srbi_pkg::KEY_W-1:0]   row_keys [srbi_pkg::N_ROWS][srbi_pkg::MAX_BLOCKS];
  logic [srbi_pkg::MASK_W-1:0]  row_bits [srbi_pkg::N_ROWS][srbi_pkg::MAX_BLOCKS];

  index_result_t         pending_results [$];
  int unsigned           mismatch_count = 0;
  int unsigned           idle_cycles = 0;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_idle_pct = 0;

  sparse_row_bitmap_index_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .cell_req_i    (cell_req_i),
    .tid_i         (tid_i),
    .bit_pos_i     (bit_pos_i),
    .block_index_i (block_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .id_o          (id_o),
    .last_o        (last_o),
    .row_blocks_o  (row_blocks_o)
  );

  always #2 clk_i = ~clk_i;

  // Append one predicted result
  function automatic void queue_result(input index_result_t res);
    pending_results = {pending_results, res};
  endfunction

  // Predict the results of one accepted request and update the row state.
  // Every 7-bit row number is a valid row, and every 5-bit bit position fits
  // in a word, so appended blocks never stay empty.
  function automatic void predict_index_results(
      input logic                            kind,
      input logic [srbi_pkg::CELL_REQ_W-1:0] row,
      input logic [srbi_pkg::TID_W-1:0]      tid,
      input logic [srbi_pkg::BIT_POS_W-1:0]  bpos,
      input logic [srbi_pkg::INDEX_W-1:0]    idx);
    int unsigned                 fill;
    int                          top;
    logic [srbi_pkg::KEY_W-1:0]  key;
    logic [srbi_pkg::MASK_W-1:0] bits;
    logic [srbi_pkg::ID_W-1:0]   origin;
    index_result_t               res;
    fill = row_fill[row];
    if (kind == srbi_pkg::KIND_INSERT) begin
      key = srbi_pkg::KEY_W'(tid / srbi_pkg::WORD_BITS);
      res = '{status: srbi_pkg::ST_OK, id: '0, last: 1'b1,
              blocks: srbi_pkg::CNT_W'(fill)};
      if (fill == 0 || row_keys[row][fill-1] != key) begin
        if (fill >= srbi_pkg::MAX_BLOCKS) begin
          // row full: dropped, nothing changes
          res.status = srbi_pkg::ST_FULL;
          queue_result(res);
          return;
        end
        row_keys[row][fill] = key;
        row_bits[row][fill] = '0;
        fill++;
        row_fill[row] = fill;
      end
      if (int'(bpos) < srbi_pkg::WORD_BITS)
        row_bits[row][fill-1][bpos] = 1'b1;
      res.blocks = srbi_pkg::CNT_W'(fill);
      queue_result(res);
    end else begin
      if (int'(idx) >= int'(fill)) begin
        queue_result('{status: srbi_pkg::ST_BAD_INDEX, id: '0, last: 1'b1,
                       blocks: srbi_pkg::CNT_W'(fill)});
        return;
      end
      bits   = row_bits[row][idx];
      origin = srbi_pkg::ID_W'(row_keys[row][idx] * srbi_pkg::WORD_BITS);
      top    = -1;
      for (int b = 0; b < srbi_pkg::DEC_W; b++)
        if (bits[b]) top = b;
      // one id per set bit, lowest first; an empty mask yields nothing
      for (int b = 0; b < srbi_pkg::DEC_W; b++) begin
        if (bits[b])
          queue_result('{status: srbi_pkg::ST_OK, id: origin + srbi_pkg::ID_W'(b),
                         last: (b == top), blocks: srbi_pkg::CNT_W'(fill)});
      end
    end
  endfunction

  function automatic void note_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  // Present one request and hold it until the transfer
  task automatic send_item(input logic                            kind,
                           input logic [srbi_pkg::CELL_REQ_W-1:0] row,
                           input logic [srbi_pkg::TID_W-1:0]      tid,
                           input logic [srbi_pkg::BIT_POS_W-1:0]  bpos,
                           input logic [srbi_pkg::INDEX_W-1:0]    idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    cell_req_i    <= row;
    tid_i         <= tid;
    bit_pos_i     <= bpos;
    block_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_index_results(kind, row, tid, bpos, idx);
  endtask

  task automatic insert_bit(input logic [srbi_pkg::CELL_REQ_W-1:0] row,
                            input logic [srbi_pkg::TID_W-1:0]      tid,
                            input logic [srbi_pkg::BIT_POS_W-1:0]  bpos);
    send_item(srbi_pkg::KIND_INSERT, row, tid, bpos,
              srbi_pkg::INDEX_W'($urandom_range(15)));
  endtask

  task automatic read_block(input logic [srbi_pkg::CELL_REQ_W-1:0] row,
                            input logic [srbi_pkg::INDEX_W-1:0]    idx);
    send_item(srbi_pkg::KIND_READ, row, srbi_pkg::TID_W'($urandom),
              srbi_pkg::BIT_POS_W'($urandom_range(31)), idx);
  endtask

  // Hold off the sender until every predicted result has been seen
  task automatic wait_for_drain;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Field extremes, bad index and an empty row
  task automatic test_extremes;
    insert_bit(7'd0, 21'd0, 5'd0);
    insert_bit(7'd0, 21'd0, 5'd31);
    read_block(7'd0, 4'd0);
    insert_bit(7'd127, 21'h1FFFFF, 5'd31);
    read_block(7'd127, 4'd0);
    read_block(7'd127, 4'd15);
    read_block(7'd5, 4'd0);
  endtask

  // Fill one row, overflow it, then OR into its last block while full
  task automatic test_full_row;
    for (int k = 0; k < srbi_pkg::MAX_BLOCKS; k++)
      insert_bit(FULL_ROW, srbi_pkg::TID_W'((100 + 3 * k) * srbi_pkg::WORD_BITS + k),
                 srbi_pkg::BIT_POS_W'(k));
    insert_bit(FULL_ROW, srbi_pkg::TID_W'(1000 * srbi_pkg::WORD_BITS), 5'd3);
    insert_bit(FULL_ROW,
               srbi_pkg::TID_W'((100 + 3 * (srbi_pkg::MAX_BLOCKS - 1)) * srbi_pkg::WORD_BITS),
               5'd31);
    wait_for_drain();
    read_block(FULL_ROW, 4'd15);
    read_block(FULL_ROW, 4'd0);
  endtask

  // Mostly runs of inserts into a few busy rows with reads of their blocks
  task automatic test_random_mix(input int n_items);
    int unsigned                     pick;
    int unsigned                     fill;
    logic [srbi_pkg::CELL_REQ_W-1:0] row;
    logic [srbi_pkg::TID_W-1:0]      tid;
    logic [srbi_pkg::KEY_W-1:0]      key;
    logic [srbi_pkg::INDEX_W-1:0]    idx;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(9);
      if (pick < 7) row = srbi_pkg::CELL_REQ_W'(pick % 4);
      else if (pick == 7) row = FULL_ROW;
      else row = srbi_pkg::CELL_REQ_W'($urandom_range(srbi_pkg::N_ROWS - 1));
      fill = row_fill[row];
      if ($urandom_range(9) < 6) begin
        pick = $urandom_range(9);
        if (fill != 0 && pick < 5) key = row_keys[row][fill-1];
        else if (pick < 8) key = srbi_pkg::KEY_W'($urandom_range(63));
        else key = srbi_pkg::KEY_W'($urandom_range(65535));
        tid = srbi_pkg::TID_W'(int'(key) * srbi_pkg::WORD_BITS
                               + int'($urandom_range(srbi_pkg::WORD_BITS - 1)));
        if (pick == 9) tid = srbi_pkg::TID_W'($urandom);
        insert_bit(row, tid, srbi_pkg::BIT_POS_W'($urandom_range(31)));
      end else begin
        if (fill != 0 && $urandom_range(4) != 0)
          idx = srbi_pkg::INDEX_W'($urandom_range(fill - 1));
        else idx = srbi_pkg::INDEX_W'($urandom_range(15));
        read_block(row, idx);
      end
    end
  endtask

  // Result side: random backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    index_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected result: status %0d id %0d last %0d blocks %0d",
                   $realtime, status_o, id_o, last_o, row_blocks_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) note_mismatch("status", want.status, status_o);
        if (id_o !== want.id) note_mismatch("id", want.id, id_o);
        if (last_o !== want.last) note_mismatch("last", want.last, last_o);
        if (row_blocks_o !== want.blocks) note_mismatch("row_blocks", want.blocks, row_blocks_o);
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    out_ready_i   = 1'b0;
    kind_i        = srbi_pkg::KIND_INSERT;
    cell_req_i    = '0;
    tid_i         = '0;
    bit_pos_i     = '0;
    block_index_i = '0;
    for (int c = 0; c < srbi_pkg::N_ROWS; c++) row_fill[c] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 12;
    recv_idle_pct = 83;
    test_extremes();
    test_full_row();
    test_random_mix(RANDOM_ITEMS);
    send_idle_pct = 83;
    recv_idle_pct = 12;
    test_random_mix(RANDOM_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(RANDOM_ITEMS);

    // let everything drain, then watch for stray results
    wait_for_drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
